/* design/mnw_pkg.sv */
// Shared types and constants for the mapped neighbourhood whitening block.
// Used by the front pipeline, the job queue, the write sequencer and the top level.
package mnw_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_X_FROM_X = 3'd0;
    localparam logic [2:0] CFG_X_FROM_Y = 3'd1;
    localparam logic [2:0] CFG_X_OFFSET = 3'd2;
    localparam logic [2:0] CFG_Y_FROM_X = 3'd3;
    localparam logic [2:0] CFG_Y_FROM_Y = 3'd4;
    localparam logic [2:0] CFG_Y_OFFSET = 3'd5;
    localparam logic [2:0] CFG_WIDTH    = 3'd6;
    localparam logic [2:0] CFG_HEIGHT   = 3'd7;

    localparam int GAIN_W    = 24;
    localparam int OFFSET_W  = 32;
    localparam int DIM_W     = 15;
    localparam int PIX_W     = 14;
    localparam int PROD_W    = 39;   // 24-bit gain times 15-bit signed pixel
    localparam int ACC_W     = 42;   // two products plus offset, exact
    localparam int MAP_W     = 27;   // rounded mapped coordinate
    localparam int SPAN_W    = 28;   // span bounds
    localparam int PITCH_W   = 13;   // row pitch in bytes, up to 4096
    localparam int BYTE_W    = 12;   // byte column, below the pitch
    localparam int OFF_W     = 25;   // byte offset into the image
    localparam int ROW_CNT_W = 4;    // rows minus one, neighbourhood up to 15
    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] FIX_HALF = 16'd32768;
    localparam logic [ACC_W-1:0] FIX_ROUND_UP = ACC_W'(65535);

    typedef struct packed {
        logic signed [GAIN_W-1:0]   x_from_x;
        logic signed [GAIN_W-1:0]   x_from_y;
        logic signed [OFFSET_W-1:0] x_offset;
        logic signed [GAIN_W-1:0]   y_from_x;
        logic signed [GAIN_W-1:0]   y_from_y;
        logic signed [OFFSET_W-1:0] y_offset;
        logic [DIM_W-1:0]           image_width;
        logic [DIM_W-1:0]           image_height;
    } mnw_cfg_t;

    // One whitening job: a rectangle of byte writes
    typedef struct packed {
        logic [OFF_W-1:0]     base;        // offset of first row, byte column 0
        logic [BYTE_W-1:0]    byte_lo;
        logic [BYTE_W-1:0]    byte_hi;
        logic [7:0]           first_mask;  // applied at byte_lo
        logic [7:0]           end_mask;    // applied at byte_hi
        logic [ROW_CNT_W-1:0] rows;        // row count minus one
    } mnw_job_t;

endpackage

/* design/mnw_front.sv */
// Front pipeline: affine map, rounding, span and clipping, job building.
// Depends on mnw_pkg; feeds jobs into mnw_queue.
module mnw_front #(
    parameter int NEIGHBOURHOOD_X = 4,
    parameter int NEIGHBOURHOOD_Y = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [13:0]                     pixel_x,
    input  logic [13:0]                     pixel_y,
    input  logic                            mask_bit,
    input  mnw_pkg::mnw_cfg_t               cfg,
    input  logic [mnw_pkg::PITCH_W-1:0]     pitch,
    input  logic                            q_full,
    output logic                            push,
    output mnw_pkg::mnw_job_t               push_job
);
    import mnw_pkg::*;

    localparam int HX    = NEIGHBOURHOOD_X / 2;
    localparam int HY    = NEIGHBOURHOOD_Y / 2;
    localparam int ODD_X = NEIGHBOURHOOD_X % 2;
    localparam int ODD_Y = NEIGHBOURHOOD_Y % 2;

    // Stage valid and work flags
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic w1_reg, w2_reg, w3_reg, w4_reg, w5_reg, w6_reg;
    logic en1, en2, en3, en4, en5, en6, en_out;

    // Stage 1: products
    logic signed [PROD_W-1:0] p_xx_reg, p_xy_reg, p_yx_reg, p_yy_reg;
    // Stage 2: sums
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;
    // Stage 3: rounded point
    logic signed [MAP_W-1:0]  mx_reg, my_reg;
    logic                     bump_x_reg, bump_y_reg;
    // Stage 4: spans
    logic signed [SPAN_W-1:0] x1_reg, x2_reg, y1_reg, y2_reg;
    // Stage 5: clipped job, row start
    mnw_job_t                 j5_reg;
    logic [DIM_W-1:0]         ylo5_reg;
    // Stage 6: complete job
    mnw_job_t                 j6_reg;

    // Backpressure chain
    assign en_out = !(v6_reg && w6_reg) || !q_full;
    assign en6 = !v6_reg || en_out;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;
    assign push     = v6_reg && w6_reg && !q_full;
    assign push_job = j6_reg;

    // Valid and work flags
    logic w5_next;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v6_reg <= 1'b0;
            w1_reg <= 1'b0; w2_reg <= 1'b0; w3_reg <= 1'b0;
            w4_reg <= 1'b0; w5_reg <= 1'b0; w6_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
                w1_reg <= !mask_bit;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
                w2_reg <= w1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
                w3_reg <= w2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
                w4_reg <= w3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
                w5_reg <= w5_next;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
                w6_reg <= w5_reg;
            end
        end
    end

    // Stage 1: four gain products
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p_xx_reg <= cfg.x_from_x * $signed({1'b0, pixel_x});
            p_xy_reg <= cfg.x_from_y * $signed({1'b0, pixel_y});
            p_yx_reg <= cfg.y_from_x * $signed({1'b0, pixel_x});
            p_yy_reg <= cfg.y_from_y * $signed({1'b0, pixel_y});
        end
    end

    // Stage 2: exact sums with offsets
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            acc_x_reg <= ACC_W'(p_xx_reg) + ACC_W'(p_xy_reg) + ACC_W'(cfg.x_offset);
            acc_y_reg <= ACC_W'(p_yx_reg) + ACC_W'(p_yy_reg) + ACC_W'(cfg.y_offset);
        end
    end

    // Stage 3: truncate toward zero, bump when remainder is above one half
    logic signed [ACC_W-1:0] up_x, up_y, qn_x, qn_y, qp_x, qp_y;
    logic                    bx_up, by_up;
    logic signed [MAP_W-1:0] mx_next, my_next;
    always_comb
    begin
        up_x  = acc_x_reg + $signed(FIX_ROUND_UP);
        up_y  = acc_y_reg + $signed(FIX_ROUND_UP);
        qn_x  = up_x >>> 16;
        qn_y  = up_y >>> 16;
        qp_x  = acc_x_reg >>> 16;
        qp_y  = acc_y_reg >>> 16;
        bx_up = !acc_x_reg[ACC_W-1] && (acc_x_reg[15:0] > FIX_HALF);
        by_up = !acc_y_reg[ACC_W-1] && (acc_y_reg[15:0] > FIX_HALF);
        if (acc_x_reg[ACC_W-1])
            mx_next = qn_x[MAP_W-1:0];
        else
            mx_next = qp_x[MAP_W-1:0] + MAP_W'(bx_up);
        if (acc_y_reg[ACC_W-1])
            my_next = qn_y[MAP_W-1:0];
        else
            my_next = qp_y[MAP_W-1:0] + MAP_W'(by_up);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            mx_reg     <= mx_next;
            my_reg     <= my_next;
            bump_x_reg <= bx_up;
            bump_y_reg <= by_up;
        end
    end

    // Stage 4: neighbourhood span; odd sizes step back by the rounding
    logic signed [SPAN_W-1:0] cx, cy;
    always_comb
    begin
        cx = SPAN_W'(mx_reg);
        cy = SPAN_W'(my_reg);
        if (ODD_X != 0)
            cx = cx - SPAN_W'(bump_x_reg);
        if (ODD_Y != 0)
            cy = cy - SPAN_W'(bump_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            x1_reg <= cx - SPAN_W'(HX);
            x2_reg <= cx + SPAN_W'(HX + ODD_X);
            y1_reg <= cy - SPAN_W'(HY);
            y2_reg <= cy + SPAN_W'(HY + ODD_Y);
        end
    end

    // Stage 5: clip columns and rows, build byte range and masks
    logic signed [SPAN_W-1:0] x1c, bxb, bxe, pitch_s, hm1, ylo, yhi, rdiff;
    logic                     byte_ok, row_ok, clipped;
    mnw_job_t                 j5_next;
    always_comb
    begin
        pitch_s = $signed(SPAN_W'(pitch));
        hm1     = $signed(SPAN_W'(cfg.image_height)) - SPAN_W'(1);
        x1c     = x1_reg[SPAN_W-1] ? '0 : x1_reg;
        bxb     = x1c >>> 3;
        bxe     = x2_reg >>> 3;
        clipped = (bxe >= pitch_s);
        byte_ok = (pitch != '0) && (bxb < pitch_s);
        ylo     = y1_reg[SPAN_W-1] ? '0 : y1_reg;
        yhi     = (y2_reg > hm1) ? hm1 : y2_reg;
        row_ok  = (ylo <= yhi);
        rdiff   = yhi - ylo;
        w5_next = w4_reg && !x2_reg[SPAN_W-1] && byte_ok && row_ok;

        j5_next            = '0;
        j5_next.byte_lo    = bxb[BYTE_W-1:0];
        j5_next.byte_hi    = clipped ? BYTE_W'(pitch - PITCH_W'(1)) : bxe[BYTE_W-1:0];
        j5_next.first_mask = 8'hFF >> x1c[2:0];
        j5_next.end_mask   = clipped ? 8'hFF : (8'hFF << (3'd7 - x2_reg[2:0]));
        j5_next.rows       = rdiff[ROW_CNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            j5_reg   <= j5_next;
            ylo5_reg <= ylo[DIM_W-1:0];
        end
    end

    // Stage 6: offset of the first (highest stored) row
    logic [DIM_W-1:0]         row_from_top;
    logic [DIM_W+PITCH_W-1:0] base_full;
    mnw_job_t                 j6_next;
    always_comb
    begin
        row_from_top = cfg.image_height - DIM_W'(1) - ylo5_reg;
        base_full    = row_from_top * pitch;
        j6_next      = j5_reg;
        j6_next.base = base_full[OFF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en6)
            j6_reg <= j6_next;
    end

endmodule

/* design/mnw_queue.sv */
// Short job queue between the front pipeline and the write sequencer.
// Depends on mnw_pkg for the job type and depth.
module mnw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mnw_pkg::mnw_job_t   push_job,
    input  logic                pop,
    output mnw_pkg::mnw_job_t   head_job,
    output logic                full,
    output logic                empty
);
    import mnw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mnw_job_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* design/mnw_back.sv */
// Write sequencer: walks a job row by row, byte by byte, one write per cycle unless out_ready stalls it.
// Depends on mnw_pkg; reads jobs from mnw_queue and drives the output register.
module mnw_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mnw_pkg::mnw_job_t           head_job,
    input  logic                        q_empty,
    output logic                        pop,
    input  logic [mnw_pkg::PITCH_W-1:0] pitch,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [24:0]                 byte_offset,
    output logic [7:0]                  or_mask,
    output logic                        last_write
);
    import mnw_pkg::*;

    mnw_job_t             job_reg;
    logic                 active_reg;
    logic [BYTE_W-1:0]    bx_reg;
    logic [ROW_CNT_W-1:0] rows_left_reg;
    logic [OFF_W-1:0]     base_reg;
    logic                 out_valid_reg;
    logic [OFF_W-1:0]     offset_reg;
    logic [7:0]           mask_reg;
    logic                 last_reg;

    logic       adv, emit, row_end, is_last;
    logic [7:0] mask_next;

    assign adv     = !out_valid_reg || out_ready;
    assign emit    = active_reg && adv;
    assign row_end = (bx_reg == job_reg.byte_hi);
    assign is_last = row_end && (rows_left_reg == '0);
    assign pop     = (!active_reg || (emit && is_last)) && !q_empty;

    // Edge masks at the first and last byte of each row
    always_comb
    begin
        mask_next = 8'hFF;
        if (bx_reg == job_reg.byte_lo)
            mask_next = mask_next & job_reg.first_mask;
        if (row_end)
            mask_next = mask_next & job_reg.end_mask;
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else if (pop)
            active_reg <= 1'b1;
        else if (emit && is_last)
            active_reg <= 1'b0;
    end

    // Job walk
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg       <= head_job;
            bx_reg        <= head_job.byte_lo;
            rows_left_reg <= head_job.rows;
            base_reg      <= head_job.base;
        end
        else if (emit)
        begin
            if (row_end)
            begin
                bx_reg        <= job_reg.byte_lo;
                rows_left_reg <= rows_left_reg - 1'b1;
                base_reg      <= base_reg - OFF_W'(pitch);
            end
            else
                bx_reg <= bx_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= active_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            offset_reg <= base_reg + OFF_W'(bx_reg);
            mask_reg   <= mask_next;
            last_reg   <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_offset = offset_reg;
    assign or_mask     = mask_reg;
    assign last_write  = last_reg;

endmodule

/* design/mapped_neighbourhood_whitening.sv */
// Throughput: one byte write per cycle unless out_ready stalls the output; an item
// makes rows x bytes writes in the write sequencer, masked items none.
// Front pipeline of six stages takes one item per cycle until the job queue fills.
// Reset: asynchronous, active low; clears control state and loads the identity
// transform with a 1x1 image.
module mapped_neighbourhood_whitening #(
    parameter int NEIGHBOURHOOD_X = 4,
    parameter int NEIGHBOURHOOD_Y = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [13:0] pixel_x,
    input  logic [13:0] pixel_y,
    input  logic        mask_bit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [24:0] byte_offset,
    output logic [7:0]  or_mask,
    output logic        last_write,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import mnw_pkg::*;

    mnw_cfg_t         cfg_reg;
    logic [PITCH_W-1:0] pitch;
    logic [DIM_W:0]     width_round;
    logic             q_full, q_empty, push, pop;
    mnw_job_t         push_job, head_job;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_from_x     <= GAIN_W'(65536);
            cfg_reg.x_from_y     <= '0;
            cfg_reg.x_offset     <= '0;
            cfg_reg.y_from_x     <= '0;
            cfg_reg.y_from_y     <= GAIN_W'(65536);
            cfg_reg.y_offset     <= '0;
            cfg_reg.image_width  <= DIM_W'(1);
            cfg_reg.image_height <= DIM_W'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_X_FROM_X: cfg_reg.x_from_x     <= cfg_data[GAIN_W-1:0];
                CFG_X_FROM_Y: cfg_reg.x_from_y     <= cfg_data[GAIN_W-1:0];
                CFG_X_OFFSET: cfg_reg.x_offset     <= cfg_data;
                CFG_Y_FROM_X: cfg_reg.y_from_x     <= cfg_data[GAIN_W-1:0];
                CFG_Y_FROM_Y: cfg_reg.y_from_y     <= cfg_data[GAIN_W-1:0];
                CFG_Y_OFFSET: cfg_reg.y_offset     <= cfg_data;
                CFG_WIDTH:    cfg_reg.image_width  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:   cfg_reg.image_height <= cfg_data[DIM_W-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Row pitch: width rounded up to 32-bit words, in bytes
    assign width_round = {1'b0, cfg_reg.image_width} + (DIM_W + 1)'(31);
    assign pitch       = {width_round[DIM_W:5], 2'b00};

    mnw_front #(
        .NEIGHBOURHOOD_X(NEIGHBOURHOOD_X),
        .NEIGHBOURHOOD_Y(NEIGHBOURHOOD_Y)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .mask_bit (mask_bit),
        .cfg      (cfg_reg),
        .pitch    (pitch),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    mnw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    mnw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .q_empty     (q_empty),
        .pop         (pop),
        .pitch       (pitch),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_offset (byte_offset),
        .or_mask     (or_mask),
        .last_write  (last_write)
    );

endmodule

/* design/mnw_checker.sv */
// Port-level checks on the write channel of the whitening block.
// Attached to mapped_neighbourhood_whitening by the bind below; no package use.
module mnw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [24:0] byte_offset,
    input logic [7:0]  or_mask,
    input logic        last_write
);

    // No write shows while reset is held
    a_idle_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("write valid during reset");

    // A stalled write holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_offset)
            && $stable(or_mask) && $stable(last_write))
        else $error("stalled write changed");

    // Every write sets at least one pixel
    a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> or_mask != 8'h00)
        else $error("empty write mask");

endmodule

bind mapped_neighbourhood_whitening mnw_checker u_mnw_checker (.*);

/* dv/mapped_neighbourhood_whitening_tb.sv */
// Self-checking testbench for mapped_neighbourhood_whitening: directed corners, then random
// warps and pixels, each byte write checked against a typed expectation or the in-bench whitening predictor.
// Depends on mnw_pkg (register indexes) and the mapped_neighbourhood_whitening RTL.
module mapped_neighbourhood_whitening_tb;
    import mnw_pkg::*;

    localparam int NBHD_X = 4;
    localparam int NBHD_Y = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES = 30;
    localparam int LONG_HOLD = 300;
    localparam int ITEMS_PER_WARP = 40;

    // One byte write of the ticket image
    typedef struct packed {
        logic [24:0] byte_offset;
        logic [7:0]  or_mask;
        logic        last_write;
    } image_write_t;

    // Raw register words of one warp and image size
    typedef struct packed {
        logic [31:0] xx;
        logic [31:0] xy;
        logic [31:0] xo;
        logic [31:0] yx;
        logic [31:0] yy;
        logic [31:0] yo;
        logic [14:0] w;
        logic [14:0] h;
    } warp_setting_t;

    typedef enum logic [2:0] {
        SET_RESET, SET_HALF, SET_MIRROR, SET_EXTREME, SET_TALL, SET_NO_WIDTH, SET_NO_HEIGHT
    } corner_e;

    typedef enum logic [1:0] {BY_MODEL, NO_WRITES, ONE_WRITE} probe_check_e;

    typedef struct packed {
        corner_e      setting;
        logic [13:0]  px;
        logic [13:0]  py;
        logic         mb;
        probe_check_e check;
        logic [24:0]  off;
        logic [7:0]   msk;
    } probe_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [13:0] pixel_x = '0;
    logic [13:0] pixel_y = '0;
    logic        mask_bit = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [24:0] byte_offset;
    logic [7:0]  or_mask;
    logic        last_write;
    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index = CFG_X_FROM_X;
    logic [31:0] cfg_data = '0;

    mapped_neighbourhood_whitening #(
        .NEIGHBOURHOOD_X(NBHD_X),
        .NEIGHBOURHOOD_Y(NBHD_Y)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .mask_bit(mask_bit),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .byte_offset(byte_offset),
        .or_mask(or_mask),
        .last_write(last_write),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    warp_setting_t corner_settings [7] = '{
        '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 15'd1, 15'd1},
        '{32'h0001_0000, 32'h0, 32'h0000_8000, 32'h0, 32'h0001_0000, 32'h0000_8001,
          15'd40, 15'd20},
        '{32'hFFFF_0000, 32'h0, 32'h0004_8001, 32'h0, 32'h0001_0000, 32'hFFFF_7FFF,
          15'd16384, 15'd16384},
        '{32'h007F_FFFF, 32'h0080_0000, 32'h7FFF_FFFF, 32'h0080_0000, 32'h007F_FFFF,
          32'h8000_0000, 15'h7FFF, 15'h7FFF},
        '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 15'h7FFF, 15'h7FFF},
        '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 15'd0, 15'd8},
        '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 15'd32, 15'd0}
    };

    // Directed corners; typed expectations only where obvious
    probe_t directed_probes [21] = '{
        '{SET_RESET, 14'd0, 14'd0, 1'b0, ONE_WRITE, 25'd0, 8'hE0},
        '{SET_RESET, 14'd5, 14'd0, 1'b0, ONE_WRITE, 25'd0, 8'h1F},
        '{SET_RESET, 14'd0, 14'd0, 1'b1, NO_WRITES, 25'd0, 8'h00},
        '{SET_RESET, 14'd16383, 14'd0, 1'b0, NO_WRITES, 25'd0, 8'h00},
        '{SET_RESET, 14'd0, 14'd16383, 1'b0, NO_WRITES, 25'd0, 8'h00},
        '{SET_RESET, 14'd16383, 14'd16383, 1'b1, NO_WRITES, 25'd0, 8'h00},
        '{SET_HALF, 14'd0, 14'd0, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_HALF, 14'd10, 14'd5, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_HALF, 14'd39, 14'd19, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_MIRROR, 14'd0, 14'd0, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_MIRROR, 14'd3, 14'd0, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_MIRROR, 14'd10, 14'd1, 1'b0, NO_WRITES, 25'd0, 8'h00},
        '{SET_MIRROR, 14'd7, 14'd5, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_EXTREME, 14'd0, 14'd0, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_EXTREME, 14'd16383, 14'd0, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_EXTREME, 14'd16383, 14'd16383, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_TALL, 14'd0, 14'd0, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_TALL, 14'd100, 14'd3, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_TALL, 14'd16383, 14'd16383, 1'b0, BY_MODEL, 25'd0, 8'h00},
        '{SET_NO_WIDTH, 14'd2, 14'd2, 1'b0, NO_WRITES, 25'd0, 8'h00},
        '{SET_NO_HEIGHT, 14'd2, 14'd2, 1'b0, NO_WRITES, 25'd0, 8'h00}
    };

    warp_setting_t active_setting = '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
                                      32'h0, 15'd1, 15'd1};
    corner_e       active_corner = SET_RESET;
    image_write_t  pending_writes[$];
    image_write_t  oldest_write;
    int            mismatches = 0;
    int            cycle_count = 0;
    int            tx_idle_pct = 37;
    int            rx_idle_pct = 82;
    int            stall_requests = 0;
    int            stalls_served = 0;
    int            hold_left = 0;

    // Neighbourhood bounds along one axis
    function automatic void neighbourhood_span(input longint c, input bit rounded_up,
                                               input int n, output longint lo,
                                               output longint hi);
        longint half;
        longint mid;
        half = n / 2;
        if (n % 2 != 0) begin
            mid = rounded_up ? c - 1 : c;
            lo = mid - half;
            hi = mid + half + 1;
        end else begin
            lo = c - half;
            hi = c + half;
        end
    endfunction

    // Expected byte writes for one accepted pixel, appended to pending_writes
    function automatic void predict_whitening(input logic [13:0] px, input logic [13:0] py,
                                              input logic mb);
        longint acc_x, acc_y, map_x, map_y, x1, x2, y1, y2;
        longint pitch, height, first_byte, final_byte, row, col;
        bit up_x, up_y;
        logic [7:0] m;
        int first_idx;
        image_write_t wr;
        if (mb)
            return;
        acc_x = longint'($signed(active_setting.xx[23:0])) * longint'(px)
              + longint'($signed(active_setting.xy[23:0])) * longint'(py)
              + longint'($signed(active_setting.xo));
        acc_y = longint'($signed(active_setting.yx[23:0])) * longint'(px)
              + longint'($signed(active_setting.yy[23:0])) * longint'(py)
              + longint'($signed(active_setting.yo));
        // Truncate toward zero, bump only above one half
        map_x = acc_x / 65536;
        up_x = (acc_x % 65536) > 32768;
        if (up_x)
            map_x++;
        map_y = acc_y / 65536;
        up_y = (acc_y % 65536) > 32768;
        if (up_y)
            map_y++;
        neighbourhood_span(map_x, up_x, NBHD_X, x1, x2);
        neighbourhood_span(map_y, up_y, NBHD_Y, y1, y2);
        if (x2 < 0)
            return;
        if (x1 < 0)
            x1 = 0;
        pitch = ((longint'(active_setting.w) + 31) / 32) * 4;
        height = longint'(active_setting.h);
        first_byte = x1 / 8;
        final_byte = x2 / 8;
        first_idx = pending_writes.size();
        for (row = y1; row <= y2; row++) begin
            if (row < 0 || row >= height)
                continue;
            for (col = first_byte; col <= final_byte && col < pitch; col++) begin
                m = 8'hFF;
                if (col == first_byte)
                    m = m & (8'hFF >> int'(x1 % 8));
                if (col == final_byte)
                    m = m & 8'(8'hFF << int'(7 - x2 % 8));
                wr.byte_offset = 25'((height - 1 - row) * pitch + col);
                wr.or_mask = m;
                wr.last_write = 1'b0;
                pending_writes.push_back(wr);
            end
        end
        if (pending_writes.size() > first_idx)
            pending_writes[pending_writes.size() - 1].last_write = 1'b1;
    endfunction

    function automatic int jitter(input int spread);
        return int'($urandom_range(0, spread)) - spread / 2;
    endfunction

    // Random warp: mostly ones that land pixels in the image, a few wild ones
    task automatic make_random_setting(output warp_setting_t s, output int x_reach,
                                       output int y_reach);
        int mode;
        mode = $urandom_range(0, 9);
        x_reach = 16383;
        y_reach = 16383;
        s.w = 15'($urandom_range(1, 200));
        s.h = 15'($urandom_range(1, 120));
        s.xx = 32'(65536 + jitter(24000));
        s.xy = 32'(jitter(8000));
        s.yx = 32'(jitter(8000));
        s.yy = 32'(65536 + jitter(24000));
        s.xo = 32'(jitter(12) * 65536 + int'($urandom_range(0, 65535)));
        s.yo = 32'(jitter(12) * 65536 + int'($urandom_range(0, 65535)));
        if (mode <= 4) begin
            x_reach = int'(s.w) + 8;
            y_reach = int'(s.h) + 8;
        end else if (mode <= 6) begin
            // mirrored axes
            s.xx = 32'(-65536 + jitter(8000));
            s.yy = 32'(-65536 + jitter(8000));
            s.xo = 32'((int'(s.w) + jitter(6)) * 65536 + int'($urandom_range(0, 65535)));
            s.yo = 32'((int'(s.h) + jitter(6)) * 65536 + int'($urandom_range(0, 65535)));
            x_reach = int'(s.w) + 8;
            y_reach = int'(s.h) + 8;
        end else if (mode == 7) begin
            // strong downscale, pixels drawn over the full range
            s.xx = 32'($urandom_range(256, 4096));
            s.xy = 32'(jitter(512));
            s.yx = 32'(jitter(512));
            s.yy = 32'($urandom_range(256, 4096));
            s.w = 15'($urandom_range(8, 700));
            s.h = 15'($urandom_range(8, 300));
        end else if (mode == 8) begin
            s.xx = $urandom;
            s.xy = $urandom;
            s.xo = $urandom;
            s.yx = $urandom;
            s.yy = $urandom;
            s.yo = $urandom;
            s.w = 15'($urandom_range(0, 32767));
            s.h = 15'($urandom_range(0, 32767));
        end else begin
            s.xo = $urandom;
            s.yo = $urandom;
            s.w = 15'($urandom_range(16000, 32767));
            s.h = 15'($urandom_range(16000, 32767));
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_setting(input warp_setting_t s);
        write_reg(CFG_X_FROM_X, s.xx);
        write_reg(CFG_X_FROM_Y, s.xy);
        write_reg(CFG_X_OFFSET, s.xo);
        write_reg(CFG_Y_FROM_X, s.yx);
        write_reg(CFG_Y_FROM_Y, s.yy);
        write_reg(CFG_Y_OFFSET, s.yo);
        write_reg(CFG_WIDTH, {17'd0, s.w});
        write_reg(CFG_HEIGHT, {17'd0, s.h});
        cfg_write_en <= 1'b0;
        active_setting = s;
    endtask

    // Stop offering, wait for every expected write, then let masked items drain
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic offer_pixel(input logic [13:0] px, input logic [13:0] py, input logic mb,
                               input probe_check_e check, input logic [24:0] want_off,
                               input logic [7:0] want_mask);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        mask_bit <= mb;
        do
            @(posedge clk);
        while (!in_ready);
        case (check)
            ONE_WRITE: pending_writes.push_back('{want_off, want_mask, 1'b1});
            NO_WRITES: ;
            default: predict_whitening(px, py, mb);
        endcase
    endtask

    // Receiver: random back-pressure plus requested long hold-offs
    always @(posedge clk) begin
        if (stalls_served != stall_requests) begin
            stalls_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Write checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_writes.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected write: off %h mask %h last %b",
                             byte_offset, or_mask, last_write);
                mismatches++;
            end else begin
                oldest_write = pending_writes.pop_front();
                if (oldest_write.byte_offset !== byte_offset || oldest_write.or_mask !== or_mask
                    || oldest_write.last_write !== last_write) begin
                    if (mismatches < 10)
                        $display("write mismatch: expected %h/%h/%b, got %h/%h/%b",
                                 oldest_write.byte_offset, oldest_write.or_mask,
                                 oldest_write.last_write, byte_offset, or_mask, last_write);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("mapped_neighbourhood_whitening_tb: errors");
            $finish;
        end
    end

    int           phase_idx;
    int           part_idx;
    int           item_idx;
    int           x_reach;
    int           y_reach;
    warp_setting_t rand_setting;
    logic [13:0]  rand_x;
    logic [13:0]  rand_y;
    logic         rand_mb;

    initial begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners
        foreach (directed_probes[i]) begin
            if (directed_probes[i].setting != active_corner) begin
                settle_block();
                load_setting(corner_settings[directed_probes[i].setting]);
                active_corner = directed_probes[i].setting;
            end
            offer_pixel(directed_probes[i].px, directed_probes[i].py, directed_probes[i].mb,
                        directed_probes[i].check, directed_probes[i].off,
                        directed_probes[i].msk);
        end

        // Random warps under three idling mixes
        for (phase_idx = 0; phase_idx < 3; phase_idx++) begin
            tx_idle_pct = (phase_idx == 0) ? 37 : (phase_idx == 1) ? 82 : 0;
            rx_idle_pct = (phase_idx == 0) ? 82 : (phase_idx == 1) ? 37 : 0;
            for (part_idx = 0; part_idx < 2; part_idx++) begin
                settle_block();
                make_random_setting(rand_setting, x_reach, y_reach);
                load_setting(rand_setting);
                for (item_idx = 0; item_idx < ITEMS_PER_WARP; item_idx++) begin
                    if (phase_idx == 1 && part_idx == 0 && item_idx == 10)
                        stall_requests++;
                    if (phase_idx == 0 && part_idx == 1 && item_idx == 20)
                        settle_block();
                    if ($urandom_range(0, 99) < 85) begin
                        rand_x = 14'($urandom_range(0, (x_reach > 16383) ? 16383 : x_reach));
                        rand_y = 14'($urandom_range(0, (y_reach > 16383) ? 16383 : y_reach));
                    end else begin
                        rand_x = 14'($urandom_range(0, 16383));
                        rand_y = 14'($urandom_range(0, 16383));
                    end
                    rand_mb = ($urandom_range(0, 99) < 20);
                    offer_pixel(rand_x, rand_y, rand_mb, BY_MODEL, 25'd0, 8'h00);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("mapped_neighbourhood_whitening_tb: clean");
        else
            $display("mapped_neighbourhood_whitening_tb: errors");
        $finish;
    end

endmodule

/* sim.f */
design/mnw_pkg.sv
design/mnw_front.sv
design/mnw_queue.sv
design/mnw_back.sv
design/mapped_neighbourhood_whitening.sv
design/mnw_checker.sv
dv/mapped_neighbourhood_whitening_tb.sv
